>>> src/rrp_pkg.sv
// Shared types, codes and constants of the reply stream parser.
package rrp_pkg;

	// Result kinds
	localparam logic [2:0] KIND_BYTE  = 3'd0;
	localparam logic [2:0] KIND_END   = 3'd1;
	localparam logic [2:0] KIND_INT   = 3'd2;
	localparam logic [2:0] KIND_COUNT = 3'd3;
	localparam logic [2:0] KIND_NULL  = 3'd4;
	localparam logic [2:0] KIND_ERROR = 3'd5;

	// Protocol error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TYPE      = 3'd1;
	localparam logic [2:0] ERR_DIGIT     = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_LIMIT     = 3'd4;
	localparam logic [2:0] ERR_ELEMENT   = 3'd5;
	localparam logic [2:0] ERR_EMPTY_NUM = 3'd6;

	// String classes as reported on the output
	localparam logic [1:0] SCLS_ERR    = 2'd0;
	localparam logic [1:0] SCLS_SIMPLE = 2'd1;
	localparam logic [1:0] SCLS_BULK   = 2'd2;

	// Protocol characters
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Configuration register indexes and reset values
	localparam logic REG_MAX_BULK  = 1'b0;
	localparam logic REG_MAX_ELEMS = 1'b1;
	localparam logic [30:0] MAX_BULK_RST  = 31'd536870912;
	localparam logic [30:0] MAX_ELEMS_RST = 31'h7FFF_FFFF;

	// Result queue geometry
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	// One result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  str_class;
		logic [7:0]  payload;
		logic [31:0] number;
		logic        member;
		logic [30:0] index;
		logic [2:0]  err;
	} result_t;

	// Results produced by one byte, from the parser core to the queue
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	// Builds a result; the element index is shown only for array members.
	function automatic result_t make_result(input logic [2:0] kind, input logic [1:0] scls,
			input logic [7:0] pb, input logic [31:0] num, input logic [2:0] err,
			input logic member, input logic [30:0] idx);
		result_t r;
		r.kind      = kind;
		r.str_class = scls;
		r.payload   = pb;
		r.number    = num;
		r.member    = member;
		r.index     = member ? idx : 31'd0;
		r.err       = err;
		return r;
	endfunction

endpackage

>>> src/rrp_core.sv
// Parser core: per-byte state update and result generation.
module rrp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic             reply_start,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [30:0]      cfg_data,
	output rrp_pkg::push_t   push
);
	import rrp_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE, PH_LINE, PH_NUM, PH_BODY, PH_TRAIL1, PH_TRAIL2, PH_ELEM, PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		CL_ERR, CL_SIMPLE, CL_BULK, CL_INT, CL_COUNT
	} class_t;

	phase_t      phase_q, ph, ph_d;
	class_t      class_q, cls, cls_d;
	logic [31:0] accum_q, acc, acc_d;
	logic        neg_q, neg, neg_d;
	logic        digit_q, dig_seen, dig_seen_d;
	logic        cr_q, cr, cr_d;
	logic [30:0] body_q, body, body_d;
	logic [30:0] elems_q, elems, elems_d;
	logic [30:0] elem_cnt_q, ec, ec_d;
	logic        in_array_q, ia, ia_d;
	logic [30:0] max_bulk_q, max_elems_q;

	logic [3:0]  dig;
	logic        is_digit;
	logic [35:0] next_val, limit;
	logic        is_null;
	logic [31:0] val;
	logic [2:0]  fail_code;
	logic        elem_done;
	logic [30:0] elems_dec;
	logic [1:0]  n;
	result_t     r0, r1;

	// Decimal digit step and number completion values
	assign dig      = rx_byte[3:0];
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	// Next state and results for the byte in the input register
	always_comb begin
		// A reply start clears the parser before the byte is looked at.
		ph       = reply_start ? PH_TYPE : phase_q;
		cls      = reply_start ? CL_ERR : class_q;
		acc      = reply_start ? 32'd0 : accum_q;
		neg      = reply_start ? 1'b0 : neg_q;
		dig_seen = reply_start ? 1'b0 : digit_q;
		cr       = reply_start ? 1'b0 : cr_q;
		body     = reply_start ? 31'd0 : body_q;
		elems    = reply_start ? 31'd0 : elems_q;
		ec       = reply_start ? 31'd0 : elem_cnt_q;
		ia       = reply_start ? 1'b0 : in_array_q;

		ph_d = ph; cls_d = cls; acc_d = acc; neg_d = neg; dig_seen_d = dig_seen;
		cr_d = cr; body_d = body; elems_d = elems; ec_d = ec; ia_d = ia;

		next_val  = {4'd0, acc} * 36'd10 + {32'd0, dig};
		limit     = neg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
		is_null   = neg && (acc != 32'd0);
		val       = neg ? (32'd0 - acc) : acc;
		elems_dec = elems - 31'd1;
		fail_code = ERR_NONE;
		elem_done = 1'b0;
		n  = 2'd0;
		r0 = '0;
		r1 = '0;

		unique case (ph)
			PH_TYPE: begin
				cr_d = 1'b0;
				if (rx_byte == CH_MINUS || rx_byte == CH_PLUS) begin
					cls_d = (rx_byte == CH_MINUS) ? CL_ERR : CL_SIMPLE;
					ph_d  = PH_LINE;
				end else if (rx_byte == CH_COLON || rx_byte == CH_DOLLAR
						|| rx_byte == CH_STAR) begin
					cls_d = (rx_byte == CH_COLON) ? CL_INT
						: (rx_byte == CH_DOLLAR) ? CL_BULK : CL_COUNT;
					acc_d = 32'd0; neg_d = 1'b0; dig_seen_d = 1'b0;
					ph_d  = PH_NUM;
				end else begin
					fail_code = ERR_TYPE;
				end
			end
			PH_LINE: begin
				// A held CR followed by LF ends the line; otherwise the CR is passed on.
				if (cr && rx_byte == CH_LF) begin
					cr_d = 1'b0;
					r0   = make_result(KIND_END, cls[1:0], 8'd0, 32'd0, ERR_NONE, ia, ec);
					n    = 2'd1;
					ph_d = PH_TYPE;
				end else if (cr) begin
					r0 = make_result(KIND_BYTE, cls[1:0], CH_CR, 32'd0, ERR_NONE, ia, ec);
					if (rx_byte == CH_CR) begin
						cr_d = 1'b1;
						n    = 2'd1;
					end else begin
						cr_d = 1'b0;
						r1   = make_result(KIND_BYTE, cls[1:0], rx_byte, 32'd0, ERR_NONE,
							ia, ec);
						n    = 2'd2;
					end
				end else if (rx_byte == CH_CR) begin
					cr_d = 1'b1;
				end else begin
					r0 = make_result(KIND_BYTE, cls[1:0], rx_byte, 32'd0, ERR_NONE, ia, ec);
					n  = 2'd1;
				end
			end
			PH_NUM: begin
				if (cr) begin
					if (rx_byte != CH_LF) begin
						fail_code = ERR_DIGIT;
					end else begin
						cr_d = 1'b0;
						if (cls == CL_INT) begin
							r0   = make_result(KIND_INT, SCLS_ERR, 8'd0, val, ERR_NONE, ia, ec);
							n    = 2'd1;
							ph_d = PH_TYPE;
						end else if (cls == CL_BULK) begin
							if (is_null) begin
								r0 = make_result(KIND_NULL, SCLS_BULK, 8'd0, 32'd0, ERR_NONE,
									ia, ec);
								n  = 2'd1;
								elem_done = 1'b1;
							end else if (acc > {1'b0, max_bulk_q}) begin
								fail_code = ERR_LIMIT;
							end else begin
								body_d = acc[30:0];
								ph_d   = (acc != 32'd0) ? PH_BODY : PH_TRAIL1;
							end
						end else begin
							if (is_null) begin
								r0   = make_result(KIND_NULL, SCLS_ERR, 8'd0, 32'd0, ERR_NONE,
									ia, ec);
								n    = 2'd1;
								ph_d = PH_TYPE;
							end else if (acc > {1'b0, max_elems_q}) begin
								fail_code = ERR_LIMIT;
							end else begin
								r0 = make_result(KIND_COUNT, SCLS_ERR, 8'd0, acc, ERR_NONE,
									ia, ec);
								n  = 2'd1;
								if (acc == 32'd0) begin
									ph_d = PH_TYPE;
								end else begin
									ia_d    = 1'b1;
									elems_d = acc[30:0];
									ec_d    = 31'd0;
									ph_d    = PH_ELEM;
								end
							end
						end
					end
				end else if (rx_byte == CH_CR) begin
					if (!dig_seen) fail_code = ERR_EMPTY_NUM;
					else cr_d = 1'b1;
				end else if (rx_byte == CH_MINUS && !dig_seen && !neg) begin
					neg_d = 1'b1;
				end else if (is_digit) begin
					if (next_val > limit) begin
						fail_code = ERR_OVERFLOW;
					end else begin
						acc_d      = next_val[31:0];
						dig_seen_d = 1'b1;
					end
				end else begin
					fail_code = ERR_DIGIT;
				end
			end
			PH_BODY: begin
				r0     = make_result(KIND_BYTE, SCLS_BULK, rx_byte, 32'd0, ERR_NONE, ia, ec);
				n      = 2'd1;
				body_d = body - 31'd1;
				if (body == 31'd1) ph_d = PH_TRAIL1;
			end
			PH_TRAIL1: begin
				ph_d = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				r0 = make_result(KIND_END, SCLS_BULK, 8'd0, 32'd0, ERR_NONE, ia, ec);
				n  = 2'd1;
				elem_done = 1'b1;
			end
			PH_ELEM: begin
				if (rx_byte == CH_DOLLAR) begin
					cls_d = CL_BULK; acc_d = 32'd0; neg_d = 1'b0;
					dig_seen_d = 1'b0; cr_d = 1'b0;
					ph_d  = PH_NUM;
				end else begin
					fail_code = ERR_ELEMENT;
				end
			end
			PH_HALT: begin
				ph_d = PH_HALT;
			end
			default: begin
				ph_d = PH_HALT;
			end
		endcase

		// Completion of one bulk element, inside or outside a multi-bulk
		if (elem_done) begin
			if (ia) begin
				ec_d    = ec + 31'd1;
				elems_d = elems_dec;
				if (elems_dec == 31'd0) begin
					ia_d = 1'b0;
					ec_d = 31'd0;
					ph_d = PH_TYPE;
				end else begin
					ph_d = PH_ELEM;
				end
			end else begin
				ph_d = PH_TYPE;
			end
		end

		// A protocol error reports once and halts until the next reply start.
		if (fail_code != ERR_NONE) begin
			r0      = make_result(KIND_ERROR, SCLS_ERR, 8'd0, 32'd0, fail_code, ia, ec);
			n       = 2'd1;
			ph_d    = PH_HALT;
			ia_d    = 1'b0;
			elems_d = 31'd0;
			ec_d    = 31'd0;
		end
	end

	assign push.count = step ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

	// Parser state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			class_q     <= CL_ERR;
			accum_q     <= 32'd0;
			neg_q       <= 1'b0;
			digit_q     <= 1'b0;
			cr_q        <= 1'b0;
			body_q      <= 31'd0;
			elems_q     <= 31'd0;
			elem_cnt_q  <= 31'd0;
			in_array_q  <= 1'b0;
			max_bulk_q  <= MAX_BULK_RST;
			max_elems_q <= MAX_ELEMS_RST;
		end else begin
			if (step) begin
				phase_q    <= ph_d;
				class_q    <= cls_d;
				accum_q    <= acc_d;
				neg_q      <= neg_d;
				digit_q    <= dig_seen_d;
				cr_q       <= cr_d;
				body_q     <= body_d;
				elems_q    <= elems_d;
				elem_cnt_q <= ec_d;
				in_array_q <= ia_d;
			end
			if (cfg_we && cfg_index == REG_MAX_BULK) max_bulk_q <= cfg_data;
			if (cfg_we && cfg_index == REG_MAX_ELEMS) max_elems_q <= cfg_data;
		end
	end

	// A halted parser stays silent until a reply start.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_HALT && !reply_start) |-> (push.count == 2'd0))
		else $error("rrp_core: result produced while halted");

	// Inside a multi-bulk at least one element is still outstanding.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_array_q |-> (elems_q != 31'd0))
		else $error("rrp_core: array active with no elements left");

	// Two results only come from a held CR in a line that is not ended.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (cr_q && phase_q == PH_LINE && !reply_start))
		else $error("rrp_core: double result outside a line");

endmodule

>>> src/rrp_outq.sv
// Result queue: takes up to two results a cycle, presents one a cycle while m_tready is high.
module rrp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  rrp_pkg::push_t    push,
	output logic              room,
	output logic              m_tvalid,
	input  logic              m_tready,
	output rrp_pkg::result_t  head
);
	import rrp_pkg::*;

	result_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q, rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 pop;

	// Room for a worst-case byte that gives two results
	assign room     = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign head     = mem_q[rd_q];

	// Result storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_q + Q_PTR_W'(1)] <= push.r1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_PTR_W'(push.count);
			if (pop) rd_q <= rd_q + Q_PTR_W'(1);
			cnt_q <= cnt_q + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
		end
	end

	// The fill count never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("rrp_outq: fill count beyond depth");

	// Results are only pushed while two slots are free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> room)
		else $error("rrp_outq: push without room");

	// A lone pop lowers the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.count == 2'd0) |=> (cnt_q == $past(cnt_q) - Q_CNT_W'(1)))
		else $error("rrp_outq: fill count wrong after pop");

endmodule

>>> src/resp_reply_parser.sv
// Top level of the reply stream parser: input register, parser core, result queue.
// Path: with an empty queue a byte is held in the input register and its first result
// is written into the result queue, from which it is offered on the master side.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready
// stays high; a line byte after a held CR gives two results.
// Reset: arst_n clears the parser to await a type byte, empties the queue and
// loads the limit registers with their reset values.
module resp_reply_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte [7:0]
	input  logic [0:0]   s_tuser,   // reply_start [0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // payload_byte [7:0], number_value [39:8],
	                                // array_member [40], member_index [71:41],
	                                // error_code [74:72], zero [79:75]
	output logic [4:0]   m_tuser,   // result_kind [2:0], string_class [4:3]
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [30:0]  cfg_data
);
	import rrp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        room;
	logic        step;
	push_t       push;
	result_t     head;

	// The registered byte is parsed once the queue has room for two results.
	assign step     = valid_s1 && room;
	assign s_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
	end

	rrp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.reply_start (start_s1),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push)
	);

	rrp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	// Output packing
	assign m_tdata = {5'd0, head.err, head.index, head.member, head.number, head.payload};
	assign m_tuser = {head.str_class, head.kind};

endmodule
